// ===== hdl/x86_register_direct_alu_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the register-direct ALU core.
// Each macro expands to one labelled concurrent assertion on the core clock.
// ---------------------------------------------------------------------------
`ifndef X86_REGISTER_DIRECT_ALU_CORE_ASSERT_SVH
`define X86_REGISTER_DIRECT_ALU_CORE_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define X86_RDA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define X86_RDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/x86_rda_pkg.sv =====
// ---------------------------------------------------------------------------
// x86_rda_pkg
// Opcodes, status codes and the structures passed between the decoder, the
// execute unit and the register file of the register-direct ALU core.
// ---------------------------------------------------------------------------
package x86_rda_pkg;

	localparam int DATA_W = 32;
	localparam int REG_N  = 8;
	localparam int REG_AW = 3;

	// One-byte opcodes that carry a ModR/M byte.
	localparam logic [7:0] OPC_ADD  = 8'h01;
	localparam logic [7:0] OPC_SUB  = 8'h29;
	localparam logic [7:0] OPC_AND  = 8'h21;
	localparam logic [7:0] OPC_OR   = 8'h09;
	localparam logic [7:0] OPC_XOR  = 8'h31;
	localparam logic [7:0] OPC_NOT  = 8'hf7;
	localparam logic [7:0] OPC_CMP  = 8'h39;
	localparam logic [7:0] OPC_MOV  = 8'h89;
	localparam logic [7:0] OPC_XCHG = 8'h87;
	// Second byte of the two-byte signed multiply.
	localparam logic [7:0] OPC_IMUL = 8'haf;

	// Push and pop carry the register in the low three opcode bits.
	localparam logic [7:0] OPC_STACK_MASK = 8'hf8;
	localparam logic [7:0] OPC_PUSH_BASE  = 8'h50;
	localparam logic [7:0] OPC_POP_BASE   = 8'h58;

	localparam logic [1:0]        MOD_REG    = 2'b11;
	localparam logic [REG_AW-1:0] REG_ESP    = 3'd4;
	localparam logic [DATA_W-1:0] STACK_STEP = 32'd4;

	// Status codes returned with every result.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_MOD = 2'd1;
	localparam logic [1:0] ST_BAD_OP  = 2'd2;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_NOT,
		OP_CMP, OP_MOV, OP_XCHG, OP_PUSH, OP_POP, OP_BAD_MOD, OP_BAD_OP
	} op_t;

	// Decoded instruction: operation and the two register read addresses.
	typedef struct packed {
		op_t               op;
		logic [REG_AW-1:0] addr_a;
		logic [REG_AW-1:0] addr_b;
	} dec_t;

	typedef struct packed {
		logic sf;
		logic zf;
		logic of;
	} flags_t;

	// Register file and flag updates of one instruction.
	typedef struct packed {
		logic              wr0_en;
		logic [REG_AW-1:0] wr0_addr;
		logic [DATA_W-1:0] wr0_data;
		logic              wr1_en;
		logic [REG_AW-1:0] wr1_addr;
		logic [DATA_W-1:0] wr1_data;
		logic              flags_en;
		flags_t            flags;
	} wb_t;

	// One result beat.
	typedef struct packed {
		logic [DATA_W-1:0] dest_value;
		flags_t            flags;
		logic              mem_write;
		logic [DATA_W-1:0] mem_addr;
		logic [DATA_W-1:0] mem_data;
		logic [1:0]        status;
	} res_t;

endpackage

// ===== hdl/x86_register_direct_alu_core.sv =====
// ---------------------------------------------------------------------------
// x86_register_direct_alu_core
// Executes one register-direct 32-bit instruction per beat against an
// eight-entry register file and the SF, ZF and OF flags.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_ready  opcode, two_byte, modrm, stack_word
//   output   out_valid/ out_ready dest_value, flags, mem_*, status
//
// An instruction passes from acceptance to its result beat through the
// decode and register read register, then the execute unit into the result
// register. One beat is accepted in every cycle while results are taken.
// Register and flag writes land as the instruction enters the result
// register, and are forwarded to the read of the following beat.
// A stall on the output holds the result register and the instruction
// behind it; the input stalls only when both are full.
// Reset clears the register file, the flags and both valid bits.
// ---------------------------------------------------------------------------
`include "x86_register_direct_alu_core_assert.svh"

module x86_register_direct_alu_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          opcode,
	input  logic                                two_byte,
	input  logic [7:0]                          modrm,
	input  logic [x86_rda_pkg::DATA_W-1:0]      stack_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [x86_rda_pkg::DATA_W-1:0]      dest_value,
	output logic                                sign_flag,
	output logic                                zero_flag,
	output logic                                overflow_flag,
	output logic                                mem_write,
	output logic [x86_rda_pkg::DATA_W-1:0]      mem_addr,
	output logic [x86_rda_pkg::DATA_W-1:0]      mem_data,
	output logic [1:0]                          status
);
	import x86_rda_pkg::*;

	dec_t              dec_in;
	dec_t              dec_s1;
	logic              valid_s1;
	logic [DATA_W-1:0] word_s1;
	logic [DATA_W-1:0] val_a_s1;
	logic [DATA_W-1:0] val_b_s1;
	flags_t            flags_q;
	wb_t               wb;
	res_t              res;
	res_t              res_s2;
	logic              valid_s2;
	logic              in_fire;
	logic              exec_fire;

	// Handshake: execute moves into the result register when it is free.
	assign exec_fire = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || exec_fire;
	assign in_fire   = in_valid && in_ready;

	x86_rda_decode u_decode (
		.opcode   (opcode),
		.two_byte (two_byte),
		.modrm    (modrm),
		.dec      (dec_in)
	);

	x86_rda_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_fire),
		.rd_addr_a (dec_in.addr_a),
		.rd_addr_b (dec_in.addr_b),
		.wb_en     (exec_fire),
		.wb        (wb),
		.rd_a_s1   (val_a_s1),
		.rd_b_s1   (val_b_s1),
		.flags_q   (flags_q)
	);

	x86_rda_alu u_alu (
		.dec        (dec_s1),
		.val_a      (val_a_s1),
		.val_b      (val_b_s1),
		.stack_word (word_s1),
		.flags_cur  (flags_q),
		.wb         (wb),
		.res        (res)
	);

	// Decode stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Decode stage payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dec_s1  <= dec_in;
			word_s1 <= stack_word;
		end
	end

	// Result register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (exec_fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign dest_value    = res_s2.dest_value;
	assign sign_flag     = res_s2.flags.sf;
	assign zero_flag     = res_s2.flags.zf;
	assign overflow_flag = res_s2.flags.of;
	assign mem_write     = res_s2.mem_write;
	assign mem_addr      = res_s2.mem_addr;
	assign mem_data      = res_s2.mem_data;
	assign status        = res_s2.status;

	// A push reports its address as the new stack pointer.
	`X86_RDA_ASSERT_NOW(a_push_addr, out_valid && mem_write, (status == ST_OK) && (dest_value == mem_addr), "push beat with inconsistent address or status")

	// A refused instruction writes nothing.
	`X86_RDA_ASSERT_NOW(a_err_quiet, out_valid && (status != ST_OK), (dest_value == '0) && !mem_write, "error beat carries a result")

	// The input only stalls with both stages full and the output stalled.
	`X86_RDA_ASSERT_NOW(a_stall_cause, !in_ready, valid_s1 && valid_s2 && !out_ready, "input stalled without a full pipeline")

	// An accepted beat is always held in the decode stage next cycle.
	`X86_RDA_ASSERT_NEXT(a_s1_loaded, in_fire, valid_s1, "accepted beat lost")

endmodule

// ===== hdl/x86_rda_decode.sv =====
// ---------------------------------------------------------------------------
// x86_rda_decode
// Turns the opcode, prefix flag and ModR/M byte of an input beat into an
// operation code and the two register file read addresses.
// ---------------------------------------------------------------------------
module x86_rda_decode (
	input  logic [7:0]         opcode,
	input  logic               two_byte,
	input  logic [7:0]         modrm,
	output x86_rda_pkg::dec_t  dec
);
	import x86_rda_pkg::*;

	op_t  op_raw;
	logic modrm_op;

	// Classify the opcode byte.
	always_comb begin
		op_raw = OP_BAD_OP;
		if (two_byte) begin
			if (opcode == OPC_IMUL) begin
				op_raw = OP_MUL;
			end
		end else begin
			unique case (opcode)
				OPC_ADD:  op_raw = OP_ADD;
				OPC_SUB:  op_raw = OP_SUB;
				OPC_AND:  op_raw = OP_AND;
				OPC_OR:   op_raw = OP_OR;
				OPC_XOR:  op_raw = OP_XOR;
				OPC_NOT:  op_raw = OP_NOT;
				OPC_CMP:  op_raw = OP_CMP;
				OPC_MOV:  op_raw = OP_MOV;
				OPC_XCHG: op_raw = OP_XCHG;
				default: begin
					if ((opcode & OPC_STACK_MASK) == OPC_PUSH_BASE) begin
						op_raw = OP_PUSH;
					end else if ((opcode & OPC_STACK_MASK) == OPC_POP_BASE) begin
						op_raw = OP_POP;
					end
				end
			endcase
		end
	end

	assign modrm_op = (op_raw != OP_PUSH) && (op_raw != OP_POP) && (op_raw != OP_BAD_OP);

	// Memory forms of ModR/M are refused; stack ops read ESP and the named register.
	always_comb begin
		dec.op     = op_raw;
		dec.addr_a = modrm[2:0];
		dec.addr_b = modrm[5:3];
		if (modrm_op && (modrm[7:6] != MOD_REG)) begin
			dec.op = OP_BAD_MOD;
		end
		if (!modrm_op && (op_raw != OP_BAD_OP)) begin
			dec.addr_a = REG_ESP;
			dec.addr_b = opcode[2:0];
		end
	end

endmodule

// ===== hdl/x86_rda_regfile.sv =====
// ---------------------------------------------------------------------------
// x86_rda_regfile
// Eight general registers and the SF, ZF and OF flags. Two read ports are
// sampled when a beat is accepted, with the writes of the instruction that
// completes in the same cycle forwarded into the read registers.
// ---------------------------------------------------------------------------
module x86_rda_regfile (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    rd_en,
	input  logic [x86_rda_pkg::REG_AW-1:0]          rd_addr_a,
	input  logic [x86_rda_pkg::REG_AW-1:0]          rd_addr_b,
	input  logic                                    wb_en,
	input  x86_rda_pkg::wb_t                        wb,
	output logic [x86_rda_pkg::DATA_W-1:0]          rd_a_s1,
	output logic [x86_rda_pkg::DATA_W-1:0]          rd_b_s1,
	output x86_rda_pkg::flags_t                     flags_q
);
	import x86_rda_pkg::*;

	logic [DATA_W-1:0] regs_q [REG_N];

	// Read one entry as it will stand after this cycle's writes.
	function automatic logic [DATA_W-1:0] fwd_read(
		input logic [REG_AW-1:0] addr,
		input logic              en,
		input wb_t               w,
		input logic [DATA_W-1:0] stored
	);
		logic [DATA_W-1:0] v;
		v = stored;
		if (en && w.wr1_en && (w.wr1_addr == addr)) begin
			v = w.wr1_data;
		end else if (en && w.wr0_en && (w.wr0_addr == addr)) begin
			v = w.wr0_data;
		end
		return v;
	endfunction

	// Register writes; the second port wins when both name one entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_N; i++) begin
				regs_q[i] <= '0;
			end
		end else if (wb_en) begin
			if (wb.wr0_en) begin
				regs_q[wb.wr0_addr] <= wb.wr0_data;
			end
			if (wb.wr1_en) begin
				regs_q[wb.wr1_addr] <= wb.wr1_data;
			end
		end
	end

	// Flag register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (wb_en && wb.flags_en) begin
			flags_q <= wb.flags;
		end
	end

	// Registered read ports with forwarding.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_s1 <= fwd_read(rd_addr_a, wb_en, wb, regs_q[rd_addr_a]);
			rd_b_s1 <= fwd_read(rd_addr_b, wb_en, wb, regs_q[rd_addr_b]);
		end
	end

endmodule

// ===== hdl/x86_rda_alu.sv =====
// ---------------------------------------------------------------------------
// x86_rda_alu
// Executes one decoded instruction on its two operands: computes the result
// beat and the register file and flag updates.
// ---------------------------------------------------------------------------
module x86_rda_alu (
	input  x86_rda_pkg::dec_t                dec,
	input  logic [x86_rda_pkg::DATA_W-1:0]   val_a,
	input  logic [x86_rda_pkg::DATA_W-1:0]   val_b,
	input  logic [x86_rda_pkg::DATA_W-1:0]   stack_word,
	input  x86_rda_pkg::flags_t              flags_cur,
	output x86_rda_pkg::wb_t                 wb,
	output x86_rda_pkg::res_t                res
);
	import x86_rda_pkg::*;

	logic [DATA_W-1:0]     sum;
	logic [DATA_W-1:0]     diff;
	logic signed [2*DATA_W-1:0] prod;
	logic                  sum_ov;
	logic                  diff_ov;
	logic                  prod_ov;
	logic [DATA_W-1:0]     r;
	logic                  of_new;

	// Shared arithmetic.
	assign sum     = val_a + val_b;
	assign diff    = val_a - val_b;
	assign prod    = $signed(val_a) * $signed(val_b);
	assign sum_ov  = (val_a[DATA_W-1] ^ sum[DATA_W-1]) & (val_b[DATA_W-1] ^ sum[DATA_W-1]);
	assign diff_ov = (val_a[DATA_W-1] ^ val_b[DATA_W-1]) & (val_a[DATA_W-1] ^ diff[DATA_W-1]);
	// The product fits when its upper half and bit 31 all agree.
	assign prod_ov = !((&prod[2*DATA_W-1:DATA_W-1]) || !(|prod[2*DATA_W-1:DATA_W-1]));

	// Result selection and state updates per operation.
	always_comb begin
		r      = '0;
		of_new = 1'b0;
		wb     = '0;
		res    = '0;
		res.flags  = flags_cur;
		res.status = ST_OK;
		wb.wr0_addr = dec.addr_a;
		wb.wr1_addr = dec.addr_b;
		unique case (dec.op)
			OP_ADD: begin
				r = sum;
				of_new = sum_ov;
			end
			OP_SUB, OP_CMP: begin
				r = diff;
				of_new = diff_ov;
			end
			OP_MUL: begin
				r = prod[DATA_W-1:0];
				of_new = prod_ov;
			end
			OP_AND:  r = val_a & val_b;
			OP_OR:   r = val_a | val_b;
			OP_XOR:  r = val_a ^ val_b;
			OP_NOT:  r = ~val_a;
			OP_MOV, OP_XCHG: r = val_b;
			OP_PUSH: r = val_a - STACK_STEP;
			OP_POP:  r = stack_word;
			OP_BAD_MOD, OP_BAD_OP: r = '0;
			default: r = '0;
		endcase

		unique case (dec.op)
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_NOT: begin
				wb.wr0_en   = 1'b1;
				wb.wr0_data = r;
				wb.flags_en = 1'b1;
				res.dest_value = r;
			end
			OP_CMP: begin
				wb.flags_en = 1'b1;
			end
			OP_MOV: begin
				wb.wr0_en   = 1'b1;
				wb.wr0_data = r;
				res.dest_value = r;
			end
			OP_XCHG: begin
				wb.wr0_en   = 1'b1;
				wb.wr0_data = r;
				wb.wr1_en   = 1'b1;
				wb.wr1_data = val_a;
				res.dest_value = r;
			end
			OP_PUSH: begin
				wb.wr0_en   = 1'b1;
				wb.wr0_data = r;
				res.dest_value = r;
				res.mem_write  = 1'b1;
				res.mem_addr   = r;
				res.mem_data   = val_b;
			end
			OP_POP: begin
				// ESP steps up first; a pop into ESP then overwrites it.
				wb.wr0_en   = 1'b1;
				wb.wr0_data = val_a + STACK_STEP;
				wb.wr1_en   = 1'b1;
				wb.wr1_data = r;
				res.dest_value = r;
			end
			OP_BAD_MOD: res.status = ST_BAD_MOD;
			OP_BAD_OP:  res.status = ST_BAD_OP;
			default:    res.status = ST_BAD_OP;
		endcase

		wb.flags.sf = r[DATA_W-1];
		wb.flags.zf = (r == '0);
		wb.flags.of = of_new;
		if (wb.flags_en) begin
			res.flags = wb.flags;
		end
	end

endmodule

// ===== sim/x86_rda_result_checker.sv =====
// ----------------------------------------------------------------------------
// Result checker for the register-direct ALU core
// Watches both channels of the core. Each instruction beat taken on the input
// is executed against a private copy of the register file and flags, and the
// outcome is queued. Each result beat taken on the output is compared field by
// field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module x86_rda_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [7:0]                        opcode,
	input  logic                              two_byte,
	input  logic [7:0]                        modrm,
	input  logic [x86_rda_pkg::DATA_W-1:0]    stack_word,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [x86_rda_pkg::DATA_W-1:0]    dest_value,
	input  logic                              sign_flag,
	input  logic                              zero_flag,
	input  logic                              overflow_flag,
	input  logic                              mem_write,
	input  logic [x86_rda_pkg::DATA_W-1:0]    mem_addr,
	input  logic [x86_rda_pkg::DATA_W-1:0]    mem_data,
	input  logic [1:0]                        status,
	output int                                errors,
	output int                                outstanding,
	output int                                beats_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import x86_rda_pkg::*;

	// Architectural state as the core should hold it.
	logic [DATA_W-1:0] arch_regs [REG_N];
	flags_t            arch_flags;

	res_t results_due [$];
	res_t got_beat;
	res_t due_beat;
	int   mismatch_count = 0;
	int   checked_count = 0;

	assign errors = mismatch_count;
	assign beats_checked = checked_count;

	// Prints one line per mismatch and counts it.
	task automatic log_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %h, expected %h", name, got, want));
	endtask

	function automatic void set_sign_zero(input logic [DATA_W-1:0] r);
		arch_flags.sf = r[DATA_W-1];
		arch_flags.zf = (r == '0);
	endfunction

	// Executes one instruction on the private state and returns its result beat.
	function automatic res_t execute_instr(input logic [7:0] op, input logic two,
		input logic [7:0] mrm, input logic [DATA_W-1:0] word);
		res_t              res;
		logic [REG_AW-1:0] rm;
		logic [REG_AW-1:0] rg;
		logic [REG_AW-1:0] sel;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] r;
		logic [DATA_W-1:0] sp;
		logic              has_modrm;
		longint            prod;
		res = '0;
		rm = mrm[2:0];
		rg = mrm[5:3];
		sel = op[2:0];
		a = arch_regs[rm];
		b = arch_regs[rg];
		if (two) begin
			has_modrm = (op == OPC_IMUL);
		end else begin
			case (op)
				OPC_ADD, OPC_SUB, OPC_AND, OPC_OR, OPC_XOR, OPC_NOT, OPC_CMP,
				OPC_MOV, OPC_XCHG: has_modrm = 1'b1;
				default: has_modrm = 1'b0;
			endcase
		end

		if (has_modrm && mrm[7:6] != MOD_REG) begin
			res.status = ST_BAD_MOD;
		end else if (has_modrm && two) begin
			// Signed multiply: overflow when the product does not fit in 32 bits.
			prod = longint'($signed(a)) * longint'($signed(b));
			r = prod[DATA_W-1:0];
			arch_regs[rm] = r;
			res.dest_value = r;
			set_sign_zero(r);
			arch_flags.of = (prod != longint'($signed(r)));
		end else if (has_modrm) begin
			case (op)
				OPC_ADD: begin
					r = a + b;
					arch_regs[rm] = r;
					res.dest_value = r;
					set_sign_zero(r);
					arch_flags.of = (a[DATA_W-1] ^ r[DATA_W-1]) & (b[DATA_W-1] ^ r[DATA_W-1]);
				end
				OPC_SUB, OPC_CMP: begin
					// Compare keeps the destination and reports zero.
					r = a - b;
					if (op == OPC_SUB) begin
						arch_regs[rm] = r;
						res.dest_value = r;
					end
					set_sign_zero(r);
					arch_flags.of = (a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ r[DATA_W-1]);
				end
				OPC_AND, OPC_OR, OPC_XOR, OPC_NOT: begin
					case (op)
						OPC_AND: r = a & b;
						OPC_OR:  r = a | b;
						OPC_XOR: r = a ^ b;
						default: r = ~a;
					endcase
					arch_regs[rm] = r;
					res.dest_value = r;
					set_sign_zero(r);
					arch_flags.of = 1'b0;
				end
				OPC_MOV: begin
					arch_regs[rm] = b;
					res.dest_value = b;
				end
				default: begin
					// Exchange; with the same register on both sides nothing moves.
					arch_regs[rm] = b;
					arch_regs[rg] = a;
					res.dest_value = arch_regs[rm];
				end
			endcase
		end else if (!two && (op & OPC_STACK_MASK) == OPC_PUSH_BASE) begin
			// The pushed word is read before the stack pointer drops.
			r = arch_regs[sel];
			sp = arch_regs[REG_ESP] - STACK_STEP;
			arch_regs[REG_ESP] = sp;
			res.dest_value = sp;
			res.mem_write = 1'b1;
			res.mem_addr = sp;
			res.mem_data = r;
		end else if (!two && (op & OPC_STACK_MASK) == OPC_POP_BASE) begin
			// The stack pointer rises first, so a pop into it keeps the word.
			arch_regs[REG_ESP] = arch_regs[REG_ESP] + STACK_STEP;
			arch_regs[sel] = word;
			res.dest_value = word;
		end else begin
			res.status = ST_BAD_OP;
		end
		res.flags = arch_flags;
		return res;
	endfunction

	// Check the result beat first, then queue the instruction beat of this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_N; i++)
				arch_regs[i] = '0;
			arch_flags = '0;
			results_due.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got_beat.dest_value = dest_value;
				got_beat.flags.sf = sign_flag;
				got_beat.flags.zf = zero_flag;
				got_beat.flags.of = overflow_flag;
				got_beat.mem_write = mem_write;
				got_beat.mem_addr = mem_addr;
				got_beat.mem_data = mem_data;
				got_beat.status = status;
				if (results_due.size() == 0) begin
					log_mismatch("result beat with nothing expected");
				end else begin
					due_beat = results_due.pop_front();
					compare_field("dest_value", got_beat.dest_value, due_beat.dest_value);
					compare_field("sign_flag", DATA_W'(got_beat.flags.sf),
						DATA_W'(due_beat.flags.sf));
					compare_field("zero_flag", DATA_W'(got_beat.flags.zf),
						DATA_W'(due_beat.flags.zf));
					compare_field("overflow_flag", DATA_W'(got_beat.flags.of),
						DATA_W'(due_beat.flags.of));
					compare_field("mem_write", DATA_W'(got_beat.mem_write),
						DATA_W'(due_beat.mem_write));
					compare_field("mem_addr", got_beat.mem_addr, due_beat.mem_addr);
					compare_field("mem_data", got_beat.mem_data, due_beat.mem_data);
					compare_field("status", DATA_W'(got_beat.status),
						DATA_W'(due_beat.status));
					checked_count++;
				end
			end
			if (in_valid && in_ready)
				results_due.push_back(execute_instr(opcode, two_byte, modrm, stack_word));
			outstanding <= results_due.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the register-direct ALU core
// Loads registers by pops, then runs every operation, the stack corner cases
// and the unsupported encodings, followed by a long stream of random
// instructions under three mixes of sender and receiver idling and two long
// output hold-offs. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import x86_rda_pkg::*;

	// Register numbers; the stack pointer comes from the package.
	localparam logic [REG_AW-1:0] R_EAX = 3'd0;
	localparam logic [REG_AW-1:0] R_ECX = 3'd1;
	localparam logic [REG_AW-1:0] R_EDX = 3'd2;
	localparam logic [REG_AW-1:0] R_EBX = 3'd3;
	localparam logic [REG_AW-1:0] R_EBP = 3'd5;
	localparam logic [REG_AW-1:0] R_ESI = 3'd6;
	localparam logic [REG_AW-1:0] R_EDI = 3'd7;

	// Memory-operand modes the core refuses.
	localparam logic [1:0] MOD_IND    = 2'b00;
	localparam logic [1:0] MOD_DISP8  = 2'b01;
	localparam logic [1:0] MOD_DISP32 = 2'b10;

	// Opcodes the core does not implement.
	localparam logic [7:0] OPC_UNUSED_HI = 8'hff;
	localparam logic [7:0] OPC_UNUSED_LO = 8'h00;

	localparam int LONG_HOLD = 60;
	localparam int PHASE_ITEMS = 210;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        opcode;
	logic              two_byte;
	logic [7:0]        modrm;
	logic [DATA_W-1:0] stack_word;
	logic              out_valid;
	logic              out_ready;
	logic [DATA_W-1:0] dest_value;
	logic              sign_flag;
	logic              zero_flag;
	logic              overflow_flag;
	logic              mem_write;
	logic [DATA_W-1:0] mem_addr;
	logic [DATA_W-1:0] mem_data;
	logic [1:0]        status;
	int                errors;
	int                outstanding;
	int                beats_checked;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests = 0;
	int holds_served = 0;
	int instrs_sent = 0;

	x86_register_direct_alu_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .two_byte(two_byte), .modrm(modrm), .stack_word(stack_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.dest_value(dest_value), .sign_flag(sign_flag), .zero_flag(zero_flag),
		.overflow_flag(overflow_flag), .mem_write(mem_write), .mem_addr(mem_addr),
		.mem_data(mem_data), .status(status)
	);

	x86_rda_result_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .two_byte(two_byte), .modrm(modrm), .stack_word(stack_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.dest_value(dest_value), .sign_flag(sign_flag), .zero_flag(zero_flag),
		.overflow_flag(overflow_flag), .mem_write(mem_write), .mem_addr(mem_addr),
		.mem_data(mem_data), .status(status),
		.errors(errors), .outstanding(outstanding), .beats_checked(beats_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

	// Result side: random back-pressure, with a long hold-off on request.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && hold_requests != holds_served) begin
				holds_served++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [7:0] mrm_of(input logic [1:0] mode,
		input logic [REG_AW-1:0] src, input logic [REG_AW-1:0] dst);
		return {mode, src, dst};
	endfunction

	function automatic logic [7:0] push_of(input logic [REG_AW-1:0] r);
		return OPC_PUSH_BASE | {5'b0, r};
	endfunction

	function automatic logic [7:0] pop_of(input logic [REG_AW-1:0] r);
		return OPC_POP_BASE | {5'b0, r};
	endfunction

	// Words near the signed and unsigned boundaries turn up often.
	function automatic logic [DATA_W-1:0] pick_word();
		if ($urandom_range(0, 2) != 0)
			return $urandom;
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'h7fff_ffff;
			3: return 32'h8000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	function automatic logic [7:0] pick_modrm_op(input int idx);
		case (idx)
			0: return OPC_ADD;
			1: return OPC_SUB;
			2: return OPC_AND;
			3: return OPC_OR;
			4: return OPC_XOR;
			5: return OPC_NOT;
			6: return OPC_CMP;
			7: return OPC_MOV;
			8: return OPC_XCHG;
			default: return OPC_IMUL;
		endcase
	endfunction

	// Offers one instruction beat after a random gap and waits until it is taken.
	task automatic send_instr(input logic [7:0] op, input logic two,
		input logic [7:0] mrm, input logic [DATA_W-1:0] word);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		two_byte <= two;
		modrm <= mrm;
		stack_word <= word;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		instrs_sent++;
	endtask

	// Mostly well-formed register instructions, with stack traffic and some noise.
	task automatic send_random_instr();
		int pick;
		int idx;
		pick = $urandom_range(0, 99);
		idx = $urandom_range(0, 9);
		if (pick < 15) begin
			send_instr(pop_of(REG_AW'($urandom_range(0, 7))), 1'b0,
				8'($urandom_range(0, 255)), pick_word());
		end else if (pick < 25) begin
			send_instr(push_of(REG_AW'($urandom_range(0, 7))), 1'b0,
				8'($urandom_range(0, 255)), $urandom);
		end else if (pick < 85) begin
			send_instr(pick_modrm_op(idx), idx == 9,
				mrm_of(MOD_REG, REG_AW'($urandom_range(0, 7)), REG_AW'($urandom_range(0, 7))),
				$urandom);
		end else if (pick < 92) begin
			send_instr(pick_modrm_op(idx), idx == 9,
				mrm_of(2'($urandom_range(0, 2)), REG_AW'($urandom_range(0, 7)),
					REG_AW'($urandom_range(0, 7))),
				$urandom);
		end else begin
			send_instr(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)), $urandom);
		end
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= '0;
		two_byte <= 1'b0;
		modrm <= '0;
		stack_word <= '0;
		send_idle_pct = 36;
		recv_idle_pct = 52;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load operands at the signed boundaries.
		send_instr(pop_of(R_EAX), 1'b0, 8'h00, 32'h7fff_ffff);
		send_instr(pop_of(R_ECX), 1'b0, 8'hff, 32'h0000_0001);
		send_instr(pop_of(R_EDX), 1'b0, 8'h00, 32'h8000_0000);
		send_instr(pop_of(R_EBX), 1'b0, 8'h00, 32'hffff_ffff);
		// Arithmetic with signed overflow, including the multiply.
		send_instr(OPC_ADD, 1'b0, mrm_of(MOD_REG, R_ECX, R_EAX), 32'h0);
		send_instr(OPC_SUB, 1'b0, mrm_of(MOD_REG, R_ECX, R_EDX), 32'h0);
		send_instr(OPC_IMUL, 1'b1, mrm_of(MOD_REG, R_EDX, R_EDX), 32'h0);
		send_instr(OPC_CMP, 1'b0, mrm_of(MOD_REG, R_EAX, R_EAX), 32'h0);
		// Bitwise operations clear overflow; not ignores its source field.
		send_instr(OPC_AND, 1'b0, mrm_of(MOD_REG, R_EAX, R_EBX), 32'h0);
		send_instr(OPC_OR, 1'b0, mrm_of(MOD_REG, R_EBX, R_ESI), 32'h0);
		send_instr(OPC_XOR, 1'b0, mrm_of(MOD_REG, R_EBX, R_EBX), 32'h0);
		send_instr(OPC_NOT, 1'b0, mrm_of(MOD_REG, R_EBP, R_EDI), 32'h0);
		send_instr(OPC_MOV, 1'b0, mrm_of(MOD_REG, R_EDI, R_EBP), 32'h0);
		send_instr(OPC_XCHG, 1'b0, mrm_of(MOD_REG, R_ECX, R_EAX), 32'h0);
		send_instr(OPC_XCHG, 1'b0, mrm_of(MOD_REG, R_ECX, R_ECX), 32'h0);
		// Stack pointer pushed and popped, with wrap-around both ways.
		send_instr(push_of(REG_ESP), 1'b0, 8'h00, 32'h0);
		send_instr(push_of(R_EDI), 1'b0, 8'h00, 32'h0);
		send_instr(pop_of(REG_ESP), 1'b0, 8'h00, 32'hffff_fffe);
		send_instr(pop_of(R_EAX), 1'b0, 8'h00, 32'hffff_ffff);
		send_instr(pop_of(REG_ESP), 1'b0, 8'h00, 32'h0000_0000);
		send_instr(push_of(R_EAX), 1'b0, 8'h00, 32'h0);
		// Memory operands and encodings the core refuses.
		send_instr(OPC_ADD, 1'b0, mrm_of(MOD_IND, R_EAX, R_ECX), 32'h0);
		send_instr(OPC_CMP, 1'b0, mrm_of(MOD_DISP8, R_EDX, R_EBX), 32'h0);
		send_instr(OPC_IMUL, 1'b1, mrm_of(MOD_DISP32, R_ESI, R_EDI), 32'h0);
		send_instr(OPC_UNUSED_HI, 1'b0, 8'hff, 32'hffff_ffff);
		send_instr(OPC_ADD, 1'b1, mrm_of(MOD_REG, R_EAX, R_EAX), 32'h0);
		send_instr(OPC_IMUL, 1'b0, mrm_of(MOD_REG, R_EAX, R_EAX), 32'h0);
		send_instr(OPC_UNUSED_LO, 1'b1, 8'h00, 32'h0);

		// Random phases: slow receiver, then slow sender, then full rate.
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == 100)
				hold_requests++;
			send_random_instr();
		end
		send_idle_pct = 52;
		recv_idle_pct = 36;
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_random_instr();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == 50)
				hold_requests++;
			send_random_instr();
		end
		in_valid <= 1'b0;

		// Drain the pipeline, then allow spare cycles for stray beats.
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("summary: %0d instructions issued, %0d result beats compared, %0d long hold-offs",
			instrs_sent, beats_checked, holds_served);
		$display("summary: all operations, stack wrap, bad mod and bad opcode encodings");
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
